[rtl/rope_pkg.sv]
`default_nettype none

package rope_pkg;

  localparam int MAX_POSITIONS = 4096;
  localparam int MAX_ROTARY_WIDTH = 128;
  localparam int TABLE_DEPTH = MAX_POSITIONS * MAX_ROTARY_WIDTH;
  localparam int TABLE_AW = $clog2(TABLE_DEPTH);
  // Widest even head width the table rows can hold
  localparam int WIDTH_CAP = MAX_ROTARY_WIDTH - (MAX_ROTARY_WIDTH % 2);
  // Row base is a 12 x 8 bit product; one more bit holds the column offsets
  localparam int SUM_W = (TABLE_AW > 21) ? TABLE_AW : 21;

  localparam logic [7:0] WIDTH_RESET = 8'd64;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ROTATE = 1'b1;

  typedef struct packed {
    logic                      rotate;
    logic                      write_ok;
    logic                      err;
    logic [TABLE_AW-1:0]       cos_addr;
    logic [TABLE_AW-1:0]       sin_addr;
    logic signed [17:0]        wdata;
    logic signed [31:0]        x;
    logic signed [31:0]        y;
  } addr_item_t;

  typedef struct packed {
    logic                      err;
    logic signed [17:0]        cos_word;
    logic signed [17:0]        sin_word;
    logic signed [31:0]        x;
    logic signed [31:0]        y;
  } table_item_t;

endpackage

`default_nettype wire

[rtl/rotary_position_embedding.sv]
`default_nettype none

// Rotary position embedding, half-split layout. Load transfers (operation 0) write one
// Q1.16 word of the cosine/sine table at table_address; rows are position * width words,
// cosines first, sines second. Rotate transfers (operation 1) return first*cos-second*sin
// and first*sin+second*cos, rounded half up to Q16.16 and saturated; an out-of-range pair
// index or position gives zeros with index_error set. One transfer is taken every cycle while
// in_stall is low; a rotate result passes through five register stages (address, table read,
// product, sum and output), and a load yields no result.
// The table is one memory with a write port and two read ports, read and written in the
// same stage so a rotate sees every load taken before it. The table is not cleared: rotate
// only after the words it needs are loaded. Change rotary_width only while the block is idle.
module rotary_position_embedding
  import rope_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               config_write,
  input  wire logic [7:0]         config_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               operation,
  input  wire logic [18:0]        table_address,
  input  wire logic signed [17:0] table_value,
  input  wire logic [11:0]        position,
  input  wire logic [5:0]         pair_index,
  input  wire logic signed [31:0] first_value,
  input  wire logic signed [31:0] second_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      rotated_first,
  output logic signed [31:0]      rotated_second,
  output logic                    index_error
);

  logic [7:0]  rotary_width;
  logic        addr_in_ready;
  logic        addr_valid;
  logic        table_in_ready;
  addr_item_t  addr_item;
  logic        table_valid;
  logic        mac_in_ready;
  table_item_t table_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotary_width <= WIDTH_RESET;
    end else if (config_write) begin
      rotary_width <= config_data;
    end
  end

  assign in_stall = !addr_in_ready;

  rope_addr u_addr (
    .clk           (clk),
    .rst           (rst),
    .rotary_width  (rotary_width),
    .in_valid      (in_valid),
    .in_ready      (addr_in_ready),
    .operation     (operation),
    .table_address (table_address),
    .table_value   (table_value),
    .position      (position),
    .pair_index    (pair_index),
    .first_value   (first_value),
    .second_value  (second_value),
    .out_valid     (addr_valid),
    .out_ready     (table_in_ready),
    .out_item      (addr_item)
  );

  rope_table u_table (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (addr_valid),
    .in_ready  (table_in_ready),
    .in_item   (addr_item),
    .out_valid (table_valid),
    .out_ready (mac_in_ready),
    .out_item  (table_item)
  );

  rope_mac u_mac (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (table_valid),
    .in_ready       (mac_in_ready),
    .in_item        (table_item),
    .out_valid      (out_valid),
    .out_ready      (!out_stall),
    .rotated_first  (rotated_first),
    .rotated_second (rotated_second),
    .index_error    (index_error)
  );

endmodule

`default_nettype wire

[rtl/rope_addr.sv]
`default_nettype none

module rope_addr
  import rope_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         rotary_width,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               operation,
  input  wire logic [18:0]        table_address,
  input  wire logic signed [17:0] table_value,
  input  wire logic [11:0]        position,
  input  wire logic [5:0]         pair_index,
  input  wire logic signed [31:0] first_value,
  input  wire logic signed [31:0] second_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output addr_item_t              out_item
);

  logic [7:0]       width_even;
  logic [7:0]       width_eff;
  logic [6:0]       half;
  logic [19:0]      row_base;
  logic [SUM_W-1:0] cos_sum;
  logic [SUM_W-1:0] sin_sum;
  logic             err;
  addr_item_t       item_next;

  always_comb begin
    width_even = {rotary_width[7:1], 1'b0};
    if ({1'b0, width_even} > 9'(WIDTH_CAP)) begin
      width_eff = 8'(WIDTH_CAP);
    end else begin
      width_eff = width_even;
    end
    half = width_eff[7:1];
    row_base = 20'(position) * 20'(width_eff);
    cos_sum = SUM_W'(row_base) + SUM_W'(pair_index);
    sin_sum = cos_sum + SUM_W'(half);
    err = ({1'b0, pair_index} >= half)
          || (32'(position) >= 32'(MAX_POSITIONS))
          || (32'(sin_sum) >= 32'(TABLE_DEPTH));
  end

  always_comb begin
    item_next.rotate = (operation == OP_ROTATE);
    item_next.write_ok = (32'(table_address) < 32'(TABLE_DEPTH));
    item_next.err = err;
    item_next.wdata = table_value;
    item_next.x = first_value;
    item_next.y = second_value;
    if (operation == OP_ROTATE) begin
      item_next.cos_addr = cos_sum[TABLE_AW-1:0];
      item_next.sin_addr = sin_sum[TABLE_AW-1:0];
    end else begin
      item_next.cos_addr = TABLE_AW'(table_address);
      item_next.sin_addr = TABLE_AW'(table_address);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

[rtl/rope_table.sv]
`default_nettype none

module rope_table
  import rope_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  addr_item_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output table_item_t out_item
);

  logic signed [17:0] cos_sin_mem [TABLE_DEPTH];
  logic               take;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (take && !in_item.rotate && in_item.write_ok) begin
      cos_sin_mem[in_item.cos_addr] <= in_item.wdata;
    end
    if (take && in_item.rotate) begin
      out_item.cos_word <= cos_sin_mem[in_item.cos_addr];
      out_item.sin_word <= cos_sin_mem[in_item.sin_addr];
      out_item.err <= in_item.err;
      out_item.x <= in_item.x;
      out_item.y <= in_item.y;
    end
  end

  // Loads end here: they leave no item behind
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid && in_item.rotate;
    end
  end

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_item.cos_word) && $stable(out_item.sin_word)))
    else $error("table read data moved while held");

  a_load_no_item: assert property (@(posedge clk) disable iff (rst)
    (take && !in_item.rotate) |=> !out_valid)
    else $error("load transfer produced an item");

endmodule

`default_nettype wire

[rtl/rope_mac.sv]
`default_nettype none

module rope_mac
  import rope_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  table_item_t        in_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic signed [31:0] rotated_first,
  output logic signed [31:0] rotated_second,
  output logic               index_error
);

  localparam logic signed [51:0] ROUND_HALF = 52'sd32768;

  // product stage
  logic               prod_valid;
  logic               prod_err;
  logic signed [49:0] xc;
  logic signed [49:0] ys;
  logic signed [49:0] xs;
  logic signed [49:0] yc;
  // sum stage
  logic               sum_valid;
  logic               sum_err;
  logic signed [51:0] sum_first;
  logic signed [51:0] sum_second;

  logic prod_ready;
  logic sum_ready;
  logic out_ready_int;

  function automatic logic signed [31:0] round_sat(input logic signed [51:0] acc);
    logic signed [35:0] r;
    r = acc[51:16];
    if (r[35:31] == {5{r[31]}}) begin
      return r[31:0];
    end else if (r[35]) begin
      return {1'b1, 31'd0};
    end else begin
      return {1'b0, {31{1'b1}}};
    end
  endfunction

  assign out_ready_int = !out_valid || out_ready;
  assign sum_ready = !sum_valid || out_ready_int;
  assign prod_ready = !prod_valid || sum_ready;
  assign in_ready = prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= in_valid;
      end
      if (sum_ready) begin
        sum_valid <= prod_valid;
      end
      if (out_ready_int) begin
        out_valid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && in_valid) begin
      prod_err <= in_item.err;
      xc <= 50'(in_item.x) * 50'(in_item.cos_word);
      ys <= 50'(in_item.y) * 50'(in_item.sin_word);
      xs <= 50'(in_item.x) * 50'(in_item.sin_word);
      yc <= 50'(in_item.y) * 50'(in_item.cos_word);
    end
    if (sum_ready && prod_valid) begin
      sum_err <= prod_err;
      sum_first <= {{2{xc[49]}}, xc} - {{2{ys[49]}}, ys} + ROUND_HALF;
      sum_second <= {{2{xs[49]}}, xs} + {{2{yc[49]}}, yc} + ROUND_HALF;
    end
    if (out_ready_int && sum_valid) begin
      index_error <= sum_err;
      if (sum_err) begin
        rotated_first <= '0;
        rotated_second <= '0;
      end else begin
        rotated_first <= round_sat(sum_first);
        rotated_second <= round_sat(sum_second);
      end
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && index_error) |-> (rotated_first == '0 && rotated_second == '0))
    else $error("flagged item carries a non-zero result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !sum_valid && !prod_valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
